>>> src/cbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cbs_pkg;

  localparam int JOB_SLOTS     = 128;
  localparam int SLOT_BITS     = $clog2(JOB_SLOTS);
  localparam int CNT_BITS      = SLOT_BITS + 1;
  localparam int BURST_BITS    = 12;
  localparam int TICK_BITS     = 24;
  localparam int OUT_BITS      = 24;
  localparam int IDENT_BITS    = 16;
  localparam int PRIO_BITS     = 14;
  localparam int ARR_BITS      = 16;
  localparam int IN_BURST_BITS = 12;
  localparam int STAGES        = 5;
  localparam int STAGE_BITS    = 3;
  localparam int QC_BITS       = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 8;
  localparam int TA_BITS       = (TICK_BITS > ARR_BITS) ? TICK_BITS : ARR_BITS;

  localparam logic [STAGE_BITS-1:0] LAST_STAGE = STAGE_BITS'(STAGES - 1);
  localparam logic [OUT_BITS-1:0]   OUT_MAX    = '1;
  localparam logic [TICK_BITS-1:0]  TICK_MAX   = '1;
  localparam logic [QC_BITS-1:0]    QC_MAX     = '1;

  // request codes
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // policy codes
  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_PRIO = 2'd1;
  localparam logic [1:0] POL_RR   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_POLICY  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_QUANTUM = CFG_IDX_BITS'(1);

  // job phases
  localparam logic [1:0] PH_WAIT  = 2'd0;
  localparam logic [1:0] PH_READY = 2'd1;
  localparam logic [1:0] PH_IO    = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  typedef struct packed {
    logic [IDENT_BITS-1:0]                  ident;
    logic [PRIO_BITS-1:0]                   prio;
    logic [ARR_BITS-1:0]                    arrival;
    logic [STAGES-1:0][BURST_BITS-1:0]      burst;
  } job_t;

  typedef struct packed {
    logic [1:0]            phase;
    logic [STAGE_BITS-1:0] stage;
    logic [BURST_BITS-1:0] remain;
    logic [OUT_BITS-1:0]   wait_cnt;
  } prog_t;

  typedef struct packed {
    logic exec_mode;
    logic on_cpu;
  } alu_ctl_t;

  typedef struct packed {
    logic push;
    logic burst_end;
    logic job_done;
  } alu_res_t;

  typedef struct packed {
    logic                  running_valid;
    logic [6:0]            running_slot;
    logic                  finished;
    logic [IDENT_BITS-1:0] finished_ident;
    logic [OUT_BITS-1:0]   finished_wait;
    logic [OUT_BITS-1:0]   finished_turnaround;
    logic [OUT_BITS-1:0]   finished_at;
    logic                  all_done;
    logic                  load_rejected;
    logic [OUT_BITS-1:0]   tick_now;
  } res_t;

  function automatic logic [OUT_BITS-1:0] sat_out(input logic [TICK_BITS-1:0] v);
    return (v > TICK_BITS'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(v);
  endfunction

endpackage
`default_nettype wire

>>> src/cbs_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface cbs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] job_ident;
  logic [13:0] job_priority;
  logic [15:0] arrival_tick;
  logic [11:0] cpu_first;
  logic [11:0] io_first;
  logic [11:0] cpu_second;
  logic [11:0] io_second;
  logic [11:0] cpu_third;
  modport source(output valid, action, job_ident, job_priority, arrival_tick,
                 cpu_first, io_first, cpu_second, io_second, cpu_third,
                 input ready);
  modport sink(input valid, action, job_ident, job_priority, arrival_tick,
               cpu_first, io_first, cpu_second, io_second, cpu_third,
               output ready);
endinterface

interface cbs_out_if;
  logic        valid;
  logic        ready;
  logic        running_valid;
  logic [6:0]  running_slot;
  logic        finished;
  logic [15:0] finished_ident;
  logic [23:0] finished_wait;
  logic [23:0] finished_turnaround;
  logic [23:0] finished_at;
  logic        all_done;
  logic        load_rejected;
  logic [23:0] tick_now;
  modport source(output valid, running_valid, running_slot, finished, finished_ident,
                 finished_wait, finished_turnaround, finished_at, all_done,
                 load_rejected, tick_now, input ready);
  modport sink(input valid, running_valid, running_slot, finished, finished_ident,
               finished_wait, finished_turnaround, finished_at, all_done,
               load_rejected, tick_now, output ready);
endinterface

interface cbs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cbs_pkg::CFG_IDX_BITS-1:0]  index;
  logic [cbs_pkg::CFG_DATA_BITS-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/cbs_slot_alu.sv
`timescale 1ns / 1ps
`default_nettype none
module cbs_slot_alu (
  input  cbs_pkg::job_t                   ent,
  input  cbs_pkg::prog_t                  pr,
  input  cbs_pkg::alu_ctl_t               ctl,
  input  logic [cbs_pkg::TICK_BITS-1:0]   now,
  output cbs_pkg::prog_t                  nx,
  output cbs_pkg::alu_res_t               res
);

  logic [cbs_pkg::BURST_BITS-1:0] dec;
  logic [cbs_pkg::STAGE_BITS-1:0] nstg;
  logic [cbs_pkg::BURST_BITS-1:0] nburst;
  logic                           arrived;

  always_comb begin
    dec     = pr.remain - cbs_pkg::BURST_BITS'(1);
    nstg    = (pr.stage < cbs_pkg::LAST_STAGE) ? pr.stage + 1'b1 : pr.stage;
    nburst  = ent.burst[nstg];
    arrived = cbs_pkg::TA_BITS'(ent.arrival) <= cbs_pkg::TA_BITS'(now);
    nx      = pr;
    res     = '0;
    if (ctl.exec_mode) begin
      nx.remain = dec;
      if (dec == '0) begin
        res.burst_end = 1'b1;
        if (pr.stage >= cbs_pkg::LAST_STAGE) begin
          nx.phase     = cbs_pkg::PH_DONE;
          res.job_done = 1'b1;
        end else begin
          nx.stage  = nstg;
          nx.remain = nburst;
          nx.phase  = cbs_pkg::PH_IO;
        end
      end
    end else begin
      if (pr.phase == cbs_pkg::PH_WAIT && arrived) begin
        nx.phase = cbs_pkg::PH_READY;
        res.push = 1'b1;
      end
      if (pr.phase == cbs_pkg::PH_IO) begin
        nx.remain = dec;
        if (dec == '0) begin
          nx.stage  = nstg;
          nx.remain = nburst;
          nx.phase  = cbs_pkg::PH_READY;
          res.push  = 1'b1;
        end
      end
      if (nx.phase == cbs_pkg::PH_READY && !ctl.on_cpu && pr.wait_cnt != cbs_pkg::OUT_MAX) begin
        nx.wait_cnt = pr.wait_cnt + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/cbs_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module cbs_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  cbs_in_if.sink                            in_ch,
  input  logic [1:0]                        policy,
  input  logic [cbs_pkg::QC_BITS-1:0]       slice_len,
  input  logic                              out_free,
  output logic                              res_vld,
  output cbs_pkg::res_t                     res
);

  localparam int SB = cbs_pkg::SLOT_BITS;
  localparam int CB = cbs_pkg::CNT_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_PASS, S_PREEMPT, S_POP, S_QCHK, S_PCHK, S_EXRD, S_EXWB, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic [CB-1:0] idx_r, idx_nxt, loaded_r, loaded_nxt, completed_r, completed_nxt;
  logic [CB-1:0] qsize_r, qsize_nxt;
  logic          pv_r, pv_nxt, busy_r, busy_nxt, cand_vld_r, cand_vld_nxt;
  logic [SB-1:0] pidx_r, pidx_nxt, owner_r, owner_nxt, cand_r, cand_nxt;
  logic [SB-1:0] qhead_r, qhead_nxt, qtail_r, qtail_nxt;
  logic [cbs_pkg::PRIO_BITS-1:0] cprio_r, cprio_nxt;
  logic [cbs_pkg::TICK_BITS-1:0] tick_r, tick_nxt, tick_inc;
  logic [cbs_pkg::QC_BITS-1:0]   qc_r, qc_nxt;
  cbs_pkg::res_t                 res_r, res_nxt;

  // storage
  cbs_pkg::job_t  tbl_mem [cbs_pkg::JOB_SLOTS];
  cbs_pkg::prog_t prog_mem[cbs_pkg::JOB_SLOTS];
  logic [SB-1:0]  q_mem   [cbs_pkg::JOB_SLOTS];
  cbs_pkg::job_t  tbl_rd_r, tbl_wd, new_job;
  cbs_pkg::prog_t prog_rd_r, prog_wd;
  logic [SB-1:0]  q_rd_r, q_wd, tbl_wa, tbl_ra, prog_wa, prog_ra;
  logic           tbl_we, prog_we, q_we;

  cbs_pkg::alu_ctl_t alu_ctl;
  cbs_pkg::prog_t    alu_nx;
  cbs_pkg::alu_res_t alu_res;

  logic rr, issue, q_room;
  logic [cbs_pkg::TA_BITS-1:0] ta_diff;

  cbs_slot_alu u_alu (
    .ent(tbl_rd_r), .pr(prog_rd_r), .ctl(alu_ctl), .now(tick_r), .nx(alu_nx), .res(alu_res)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign rr          = (policy == cbs_pkg::POL_RR);
  assign issue       = idx_r < loaded_r;
  assign q_room      = qsize_r < CB'(cbs_pkg::JOB_SLOTS);
  assign tick_inc    = (tick_r != cbs_pkg::TICK_MAX) ? tick_r + 1'b1 : tick_r;
  assign ta_diff     = cbs_pkg::TA_BITS'(tick_r) - cbs_pkg::TA_BITS'(tbl_rd_r.arrival);

  always_comb begin
    new_job.ident    = in_ch.job_ident;
    new_job.prio     = in_ch.job_priority;
    new_job.arrival  = in_ch.arrival_tick;
    new_job.burst[0] = cbs_pkg::BURST_BITS'(in_ch.cpu_first);
    new_job.burst[1] = cbs_pkg::BURST_BITS'(in_ch.io_first);
    new_job.burst[2] = cbs_pkg::BURST_BITS'(in_ch.cpu_second);
    new_job.burst[3] = cbs_pkg::BURST_BITS'(in_ch.io_second);
    new_job.burst[4] = cbs_pkg::BURST_BITS'(in_ch.cpu_third);
  end

  always_comb begin
    res              = res_r;
    res.all_done     = completed_r >= loaded_r;
    res.tick_now     = cbs_pkg::sat_out(tick_r);
  end

  always_comb begin
    state_nxt = state_r;   idx_nxt = idx_r;       loaded_nxt = loaded_r;
    completed_nxt = completed_r;  qsize_nxt = qsize_r;  pv_nxt = 1'b0;
    busy_nxt = busy_r;     cand_vld_nxt = cand_vld_r;  pidx_nxt = pidx_r;
    owner_nxt = owner_r;   cand_nxt = cand_r;     qhead_nxt = qhead_r;
    qtail_nxt = qtail_r;   cprio_nxt = cprio_r;   tick_nxt = tick_r;
    qc_nxt = qc_r;         res_nxt = res_r;
    tbl_we = 1'b0;  tbl_wa = loaded_r[SB-1:0];  tbl_wd = new_job;
    prog_we = 1'b0; prog_wa = pidx_r;           prog_wd = alu_nx;
    q_we = 1'b0;    q_wd = pidx_r;
    tbl_ra = idx_r[SB-1:0];  prog_ra = idx_r[SB-1:0];
    alu_ctl.exec_mode = 1'b0;
    alu_ctl.on_cpu    = busy_r && (owner_r == pidx_r);
    res_vld = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_nxt = '0;
          idx_nxt = '0;
          cand_vld_nxt = 1'b0;
          unique case (in_ch.action)
            cbs_pkg::ACT_LOAD: begin
              if (loaded_r >= CB'(cbs_pkg::JOB_SLOTS)) begin
                res_nxt.load_rejected = 1'b1;
              end else begin
                tbl_we  = 1'b1;
                prog_we = 1'b1;
                prog_wa = loaded_r[SB-1:0];
                prog_wd = '{phase: cbs_pkg::PH_WAIT, stage: '0,
                            remain: new_job.burst[0], wait_cnt: '0};
                loaded_nxt = loaded_r + 1'b1;
              end
              state_nxt = S_FIN;
            end
            cbs_pkg::ACT_START: state_nxt = S_CLR;
            cbs_pkg::ACT_TICK:  state_nxt = S_PASS;
            default:            state_nxt = S_FIN;
          endcase
        end
      end
      S_CLR: begin
        if (issue) begin
          pv_nxt = 1'b1; pidx_nxt = idx_r[SB-1:0]; idx_nxt = idx_r + 1'b1;
        end
        if (pv_r) begin
          prog_we = 1'b1;
          prog_wd = '{phase: cbs_pkg::PH_WAIT, stage: '0,
                      remain: tbl_rd_r.burst[0], wait_cnt: '0};
        end
        if (!issue && !pv_r) begin
          completed_nxt = '0; tick_nxt = '0; busy_nxt = 1'b0; owner_nxt = '0;
          qc_nxt = '0; qhead_nxt = '0; qtail_nxt = '0; qsize_nxt = '0;
          state_nxt = S_FIN;
        end
      end
      S_PASS: begin
        if (issue) begin
          pv_nxt = 1'b1; pidx_nxt = idx_r[SB-1:0]; idx_nxt = idx_r + 1'b1;
        end
        if (pv_r) begin
          prog_we = 1'b1;
          if (alu_res.push && rr && q_room) begin
            q_we = 1'b1;
            qtail_nxt = qtail_r + 1'b1;
            qsize_nxt = qsize_r + 1'b1;
          end
          // lowest slot wins ties; FCFS takes the first ready slot only
          if (!rr && alu_nx.phase == cbs_pkg::PH_READY &&
              (!cand_vld_r || (policy == cbs_pkg::POL_PRIO && tbl_rd_r.prio < cprio_r))) begin
            cand_vld_nxt = 1'b1; cand_nxt = pidx_r; cprio_nxt = tbl_rd_r.prio;
          end
        end
        if (!issue && !pv_r) state_nxt = S_PREEMPT;
      end
      S_PREEMPT: begin
        if (rr && busy_r && slice_len != '0 && qc_r == slice_len) begin
          busy_nxt = 1'b0;
          if (q_room) begin
            q_we = 1'b1; q_wd = owner_r;
            qtail_nxt = qtail_r + 1'b1;
            qsize_nxt = qsize_r + 1'b1;
          end
        end
        state_nxt = S_POP;
      end
      S_POP: begin
        state_nxt = S_EXRD;
        if (!busy_r) begin
          if (rr) begin
            if (qsize_r != '0) begin
              qhead_nxt = qhead_r + 1'b1;
              qsize_nxt = qsize_r - 1'b1;
              state_nxt = S_QCHK;
            end
          end else if (cand_vld_r) begin
            busy_nxt = 1'b1; owner_nxt = cand_r; qc_nxt = '0;
          end
        end
      end
      S_QCHK: begin
        prog_ra   = q_rd_r;
        cand_nxt  = q_rd_r;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        // stale queue entries are dropped and the CPU idles this tick
        if ({1'b0, cand_r} < loaded_r && prog_rd_r.phase == cbs_pkg::PH_READY) begin
          busy_nxt = 1'b1; owner_nxt = cand_r; qc_nxt = '0;
        end
        state_nxt = S_EXRD;
      end
      S_EXRD: begin
        tbl_ra    = owner_r;
        prog_ra   = owner_r;
        tick_nxt  = tick_inc;
        state_nxt = busy_r ? S_EXWB : S_FIN;
      end
      S_EXWB: begin
        alu_ctl.exec_mode = 1'b1;
        prog_we = 1'b1;
        prog_wa = owner_r;
        res_nxt.running_valid = 1'b1;
        res_nxt.running_slot  = 7'(owner_r);
        if (qc_r != cbs_pkg::QC_MAX) qc_nxt = qc_r + 1'b1;
        if (alu_res.burst_end) busy_nxt = 1'b0;
        if (alu_res.job_done) begin
          completed_nxt = completed_r + 1'b1;
          res_nxt.finished       = 1'b1;
          res_nxt.finished_ident = tbl_rd_r.ident;
          res_nxt.finished_wait  = prog_rd_r.wait_cnt;
          res_nxt.finished_at    = cbs_pkg::sat_out(tick_r);
          res_nxt.finished_turnaround =
            (cbs_pkg::TA_BITS'(tick_r) >= cbs_pkg::TA_BITS'(tbl_rd_r.arrival)) ?
            cbs_pkg::sat_out(cbs_pkg::TICK_BITS'(ta_diff)) : '0;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          res_vld   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  idx_r <= '0;  loaded_r <= '0;  completed_r <= '0;
      qsize_r <= '0;  pv_r <= 1'b0;  busy_r <= 1'b0;  cand_vld_r <= 1'b0;
      owner_r <= '0;  qhead_r <= '0;  qtail_r <= '0;  tick_r <= '0;  qc_r <= '0;
    end else begin
      state_r <= state_nxt;  idx_r <= idx_nxt;  loaded_r <= loaded_nxt;
      completed_r <= completed_nxt;  qsize_r <= qsize_nxt;  pv_r <= pv_nxt;
      busy_r <= busy_nxt;  cand_vld_r <= cand_vld_nxt;  owner_r <= owner_nxt;
      qhead_r <= qhead_nxt;  qtail_r <= qtail_nxt;  tick_r <= tick_nxt;  qc_r <= qc_nxt;
    end
    pidx_r  <= pidx_nxt;
    cand_r  <= cand_nxt;
    cprio_r <= cprio_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    tbl_rd_r <= tbl_mem[tbl_ra];
  end

  always_ff @(posedge clk) begin
    if (prog_we) prog_mem[prog_wa] <= prog_wd;
    prog_rd_r <= prog_mem[prog_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[qtail_r] <= q_wd;
    q_rd_r <= q_mem[qhead_r];
  end

  a_qsize: assert property (@(posedge clk) disable iff (!rst_n)
    qsize_r <= CB'(cbs_pkg::JOB_SLOTS)) else $error("ready queue overfilled");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    completed_r <= loaded_r) else $error("more completions than jobs");
  a_owner: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ({1'b0, owner_r} < loaded_r)) else $error("owner outside table");
  a_grant: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> ($past(state_r) == S_POP || $past(state_r) == S_PCHK))
    else $error("CPU granted outside selection");

endmodule
`default_nettype wire

>>> src/cpu_io_burst_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Request flow: a load writes its table slot directly; start and tick each sweep the
//   loaded slots, and a tick then selects the CPU job and runs it for one tick.
// Throughput: one request at a time; the next is accepted only once the result
//   is registered. A tick is one sweep of the job table through the slot update unit.
// Reset: rst_n synchronous, clears counters, queue pointers and CPU state; job storage
//   needs no clearing pass, slots are only read below the loaded count.
module cpu_io_burst_scheduler_core (
  input  logic       clk,
  input  logic       rst_n,
  cbs_in_if.sink     in_ch,
  cbs_out_if.source  out_ch,
  cbs_cfg_if.sink    cfg_ch
);

  logic [1:0]                    policy_r;
  logic [cbs_pkg::QC_BITS-1:0]   slice_r;
  logic                          out_vld_r;
  cbs_pkg::res_t                 out_r;
  cbs_pkg::res_t                 res;
  logic                          res_vld;
  logic                          out_free;

  // config writes are always accepted; ready is tied high
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= cbs_pkg::POL_FCFS;
      slice_r  <= cbs_pkg::QC_BITS'(15);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        cbs_pkg::REG_POLICY:  policy_r <= cfg_ch.data[1:0];
        cbs_pkg::REG_QUANTUM: slice_r  <= cbs_pkg::QC_BITS'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // the engine finishes a request only when the result slot is free or draining
  assign out_free = !out_vld_r || out_ch.ready;

  cbs_engine u_engine (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .policy(policy_r),
    .slice_len(slice_r), .out_free(out_free), .res_vld(res_vld), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
    if (res_vld) out_r <= res;
  end

  assign out_ch.valid               = out_vld_r;
  assign out_ch.running_valid       = out_r.running_valid;
  assign out_ch.running_slot        = out_r.running_slot;
  assign out_ch.finished            = out_r.finished;
  assign out_ch.finished_ident      = out_r.finished_ident;
  assign out_ch.finished_wait       = out_r.finished_wait;
  assign out_ch.finished_turnaround = out_r.finished_turnaround;
  assign out_ch.finished_at         = out_r.finished_at;
  assign out_ch.all_done            = out_r.all_done;
  assign out_ch.load_rejected       = out_r.load_rejected;
  assign out_ch.tick_now            = out_r.tick_now;

endmodule
`default_nettype wire

>>> tb/sv/cpu_io_burst_scheduler_core_test.sv
`timescale 1ns / 1ps
module cpu_io_burst_scheduler_core_test;

  // Action code 3 is not defined by the block; it must change nothing.
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 500_000;
  // Drain margin after the last result; it outlasts the longest tick.
  localparam int DRAIN_CYCLES = 2 * cbs_pkg::JOB_SLOTS + 40;

  typedef struct packed {
    logic [1:0]                         act;
    logic [cbs_pkg::IDENT_BITS-1:0]     ident;
    logic [cbs_pkg::PRIO_BITS-1:0]      prio;
    logic [cbs_pkg::ARR_BITS-1:0]       arrival;
    logic [cbs_pkg::STAGES-1:0][cbs_pkg::IN_BURST_BITS-1:0] burst;
  } sched_req_t;

  logic clk;
  logic rst_n;

  cbs_in_if  in_ch();
  cbs_out_if out_ch();
  cbs_cfg_if cfg_ch();

  cpu_io_burst_scheduler_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow state: job table, per-job progress, CPU and ready queue.
  // ---------------------------------------------------------------------------
  logic [1:0]                     cur_policy;
  logic [7:0]                     cur_slice;
  logic [cbs_pkg::IDENT_BITS-1:0] tbl_ident [cbs_pkg::JOB_SLOTS];
  logic [cbs_pkg::PRIO_BITS-1:0]  tbl_prio  [cbs_pkg::JOB_SLOTS];
  logic [cbs_pkg::ARR_BITS-1:0]   tbl_arr   [cbs_pkg::JOB_SLOTS];
  logic [cbs_pkg::BURST_BITS-1:0] tbl_burst [cbs_pkg::JOB_SLOTS][cbs_pkg::STAGES];
  logic [1:0]                     pg_phase  [cbs_pkg::JOB_SLOTS];
  int                             pg_stage  [cbs_pkg::JOB_SLOTS];
  logic [cbs_pkg::BURST_BITS-1:0] pg_remain [cbs_pkg::JOB_SLOTS];
  int                             pg_wait   [cbs_pkg::JOB_SLOTS];
  int                             n_loaded;
  int                             n_done;
  logic [cbs_pkg::TICK_BITS-1:0]  ticks;
  logic                           cpu_busy;
  int                             cpu_slot;
  int                             quantum;
  int                             rq [cbs_pkg::JOB_SLOTS];
  int                             rq_head, rq_tail, rq_size;

  function automatic void rewind_job(int i);
    pg_phase[i]  = cbs_pkg::PH_WAIT;
    pg_stage[i]  = 0;
    pg_remain[i] = tbl_burst[i][0];
    pg_wait[i]   = 0;
  endfunction

  function automatic void rq_push(int slot);
    if (rq_size < cbs_pkg::JOB_SLOTS) begin
      rq[rq_tail] = slot;
      rq_tail = (rq_tail + 1) % cbs_pkg::JOB_SLOTS;
      rq_size++;
    end
  endfunction

  function automatic void restart_run();
    n_done   = 0;
    ticks    = '0;
    cpu_busy = 1'b0;
    cpu_slot = 0;
    quantum  = 0;
    rq_head  = 0;
    rq_tail  = 0;
    rq_size  = 0;
  endfunction

  // Computes the result for one accepted request and advances the shadow state.
  function automatic cbs_pkg::res_t schedule_step(sched_req_t q);
    cbs_pkg::res_t r;
    logic rr;
    logic [cbs_pkg::TICK_BITS-1:0] nxt;
    int s;
    r  = '0;
    rr = (cur_policy == cbs_pkg::POL_RR);
    case (q.act)
      cbs_pkg::ACT_LOAD: begin
        if (n_loaded >= cbs_pkg::JOB_SLOTS) begin
          r.load_rejected = 1'b1;
        end else begin
          tbl_ident[n_loaded] = q.ident;
          tbl_prio[n_loaded]  = q.prio;
          tbl_arr[n_loaded]   = q.arrival;
          for (int k = 0; k < cbs_pkg::STAGES; k++) tbl_burst[n_loaded][k] = q.burst[k];
          rewind_job(n_loaded);
          n_loaded++;
        end
      end
      cbs_pkg::ACT_START: begin
        for (int i = 0; i < n_loaded; i++) rewind_job(i);
        restart_run();
      end
      cbs_pkg::ACT_TICK: begin
        nxt = (ticks == cbs_pkg::TICK_MAX) ? cbs_pkg::TICK_MAX : ticks + 1'b1;
        // arrivals, IO countdown, wait accounting
        for (int i = 0; i < n_loaded; i++) begin
          if (pg_phase[i] == cbs_pkg::PH_WAIT &&
              cbs_pkg::TICK_BITS'(tbl_arr[i]) <= ticks) begin
            pg_phase[i] = cbs_pkg::PH_READY;
            if (rr) rq_push(i);
          end
          if (pg_phase[i] == cbs_pkg::PH_IO) begin
            pg_remain[i] = pg_remain[i] - 1'b1;
            if (pg_remain[i] == '0) begin
              if (pg_stage[i] < cbs_pkg::STAGES - 1) pg_stage[i]++;
              pg_remain[i] = tbl_burst[i][pg_stage[i]];
              pg_phase[i]  = cbs_pkg::PH_READY;
              if (rr) rq_push(i);
            end
          end
          if (pg_phase[i] == cbs_pkg::PH_READY && !(cpu_busy && cpu_slot == i))
            if (pg_wait[i] < int'(cbs_pkg::OUT_MAX)) pg_wait[i]++;
        end
        // quantum expiry under round robin
        if (rr && cpu_busy && cur_slice != 0 && quantum == int'(cur_slice)) begin
          rq_push(cpu_slot);
          cpu_busy = 1'b0;
        end
        if (!cpu_busy) begin
          if (rr) begin
            if (rq_size > 0) begin
              s = rq[rq_head];
              rq_head = (rq_head + 1) % cbs_pkg::JOB_SLOTS;
              rq_size--;
              // stale entries are dropped and the CPU idles this tick
              if (s < n_loaded && pg_phase[s] == cbs_pkg::PH_READY) begin
                cpu_busy = 1'b1;
                cpu_slot = s;
              end
            end
          end else if (cur_policy == cbs_pkg::POL_PRIO) begin
            for (int i = 0; i < n_loaded; i++)
              if (pg_phase[i] == cbs_pkg::PH_READY &&
                  (!cpu_busy || tbl_prio[i] < tbl_prio[cpu_slot])) begin
                cpu_busy = 1'b1;
                cpu_slot = i;
              end
          end else begin
            // first ready slot; policy 3 lands here as well
            for (int i = 0; i < n_loaded; i++)
              if (!cpu_busy && pg_phase[i] == cbs_pkg::PH_READY) begin
                cpu_busy = 1'b1;
                cpu_slot = i;
              end
          end
          if (cpu_busy) quantum = 0;
        end
        if (cpu_busy) begin
          r.running_valid = 1'b1;
          r.running_slot  = 7'(cpu_slot);
          pg_remain[cpu_slot] = pg_remain[cpu_slot] - 1'b1;
          if (quantum < int'(cbs_pkg::QC_MAX)) quantum++;
          if (pg_remain[cpu_slot] == '0) begin
            if (pg_stage[cpu_slot] >= cbs_pkg::STAGES - 1) begin
              pg_phase[cpu_slot]    = cbs_pkg::PH_DONE;
              n_done++;
              r.finished            = 1'b1;
              r.finished_ident      = tbl_ident[cpu_slot];
              r.finished_wait       = cbs_pkg::OUT_BITS'(pg_wait[cpu_slot]);
              r.finished_turnaround =
                (nxt >= cbs_pkg::TICK_BITS'(tbl_arr[cpu_slot])) ?
                nxt - cbs_pkg::TICK_BITS'(tbl_arr[cpu_slot]) : '0;
              r.finished_at         = nxt;
            end else begin
              pg_stage[cpu_slot]++;
              pg_remain[cpu_slot] = tbl_burst[cpu_slot][pg_stage[cpu_slot]];
              pg_phase[cpu_slot]  = cbs_pkg::PH_IO;
            end
            cpu_busy = 1'b0;
          end
        end
        ticks = nxt;
      end
      default: ;
    endcase
    r.all_done = (n_done >= n_loaded);
    r.tick_now = ticks;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, monitor and bookkeeping
  // ---------------------------------------------------------------------------
  sched_req_t    pending_reqs[$];
  cbs_pkg::res_t expected_res[$];
  sched_req_t    cur_req;
  logic          in_taken;
  int            send_idle;
  int            recv_idle;
  int            mismatches;
  int            cycles;
  int            queued_loads;

  assign in_ch.action       = cur_req.act;
  assign in_ch.job_ident    = cur_req.ident;
  assign in_ch.job_priority = cur_req.prio;
  assign in_ch.arrival_tick = cur_req.arrival;
  assign in_ch.cpu_first    = cur_req.burst[0];
  assign in_ch.io_first     = cur_req.burst[1];
  assign in_ch.cpu_second   = cur_req.burst[2];
  assign in_ch.io_second    = cur_req.burst[3];
  assign in_ch.cpu_third    = cur_req.burst[4];

  // request driver: a new request goes out on the falling edge after acceptance
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_req     <= pending_reqs.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // ready drops right after an accepting edge, so acceptance is latched here
  // for the driver instead of being re-read at the falling edge.
  always @(posedge clk) begin
    cbs_pkg::res_t got;
    if (rst_n) begin
      cycles   <= cycles + 1;
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready)
        expected_res.push_back(schedule_step(cur_req));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.running_valid, out_ch.running_slot, out_ch.finished,
                out_ch.finished_ident, out_ch.finished_wait,
                out_ch.finished_turnaround, out_ch.finished_at, out_ch.all_done,
                out_ch.load_rejected, out_ch.tick_now};
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else if (got !== expected_res[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch\n  exp %p\n  got %p", expected_res[0], got);
          void'(expected_res.pop_front());
        end else begin
          void'(expected_res.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_ctl(logic [1:0] act);
    sched_req_t q;
    q     = sched_req_t'($urandom());  // unused fields carry noise
    q.act = act;
    pending_reqs.push_back(q);
  endtask

  task automatic add_job(logic [15:0] id, logic [13:0] pr, logic [15:0] arr,
                         logic [11:0] c0, logic [11:0] i0, logic [11:0] c1,
                         logic [11:0] i1, logic [11:0] c2);
    sched_req_t q;
    q.act     = cbs_pkg::ACT_LOAD;
    q.ident   = id;
    q.prio    = pr;
    q.arrival = arr;
    q.burst   = {c2, i1, c1, i0, c0};
    pending_reqs.push_back(q);
    queued_loads++;
  endtask

  // Random job: mostly short bursts that finish; now and then wide field values
  // on a job that arrives too late to ever run.
  task automatic add_rand_job();
    if ($urandom_range(15) == 0)
      add_job(16'($urandom()), 14'($urandom()), 16'($urandom_range(65535, 40000)),
              12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
              12'($urandom()));
    else
      add_job(16'($urandom()), 14'($urandom_range(9998) % ($urandom_range(1) ? 10 : 9999)),
              16'($urandom_range(30)), 12'($urandom_range(6, 1)), 12'($urandom_range(6, 1)),
              12'($urandom_range(6, 1)), 12'($urandom_range(6, 1)), 12'($urandom_range(6, 1)));
  endtask

  task automatic add_ticks(int n);
    for (int k = 0; k < n; k++) add_ctl(cbs_pkg::ACT_TICK);
  endtask

  // Block is idle once every request is out and every result has arrived; a
  // short margin follows before any register write.
  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_ch.valid && expected_res.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [cbs_pkg::CFG_IDX_BITS-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == cbs_pkg::REG_POLICY) cur_policy = val[1:0];
    else if (idx == cbs_pkg::REG_QUANTUM) cur_slice = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int rounds;
    int pick;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    cur_req      = '0;
    in_taken     = 1'b0;
    send_idle    = 20;
    recv_idle    = 51;
    mismatches   = 0;
    cycles       = 0;
    queued_loads = 0;
    cur_policy   = cbs_pkg::POL_FCFS;
    cur_slice    = 8'd15;
    n_loaded     = 0;
    restart_run();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: a tick on an empty table, an undefined action, a priority tie,
    // one job whose arrival lies beyond reach with every field but its ident at its top value.
    add_ctl(cbs_pkg::ACT_TICK);
    add_ctl(ACT_NONE);
    add_job(16'h0000, 14'd5, 16'd0, 12'd1, 12'd1, 12'd2, 12'd1, 12'd1);
    add_job(16'hFFFF, 14'd5, 16'd2, 12'd2, 12'd3, 12'd1, 12'd2, 12'd3);
    add_job(16'h1234, 14'd9998, 16'd1, 12'd3, 12'd1, 12'd1, 12'd1, 12'd2);
    add_job(16'hA5A5, 14'h3FFF, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
            12'hFFF);
    add_ctl(cbs_pkg::ACT_START);
    add_ticks(16);
    drain();
    write_reg(cbs_pkg::REG_POLICY, 8'(cbs_pkg::POL_PRIO));
    write_reg(cbs_pkg::REG_QUANTUM, 8'd1);
    add_ctl(cbs_pkg::ACT_START);
    add_ticks(14);
    drain();
    write_reg(cbs_pkg::REG_POLICY, 8'(cbs_pkg::POL_RR));
    add_ctl(cbs_pkg::ACT_START);
    add_ticks(14);
    drain();

    // Random rounds: mostly well-formed runs (start, a few loads, many ticks),
    // with policy switches mid-run and the odd stray request.
    for (rounds = 0; rounds < 16; rounds++) begin
      if (rounds == 5) begin
        send_idle = 51;
        recv_idle = 20;
      end else if (rounds == 10) begin
        send_idle = 0;
        recv_idle = 0;
      end
      drain();  // also makes the sender hold off until nothing is pending
      pick = $urandom_range(9);
      if (pick < 4)
        write_reg(cbs_pkg::REG_POLICY, 8'($urandom_range(3)));
      if (pick < 3)
        case ($urandom_range(3))
          0: write_reg(cbs_pkg::REG_QUANTUM, 8'd0);
          1: write_reg(cbs_pkg::REG_QUANTUM, 8'd255);
          2: write_reg(cbs_pkg::REG_QUANTUM, 8'd1);
          default: write_reg(cbs_pkg::REG_QUANTUM, 8'($urandom_range(8, 2)));
        endcase
      if ($urandom_range(3) != 0) add_ctl(cbs_pkg::ACT_START);
      for (int k = $urandom_range(3); k > 0 && queued_loads < 110; k--)
        add_rand_job();
      add_ticks($urandom_range(16, 6));
      if ($urandom_range(7) == 0) add_ctl(ACT_NONE);
      if ($urandom_range(4) == 0) add_rand_job();
      add_ticks($urandom_range(4));
    end

    // Fill the table and overflow it, then run on a full table.
    drain();
    write_reg(cbs_pkg::REG_POLICY, 8'(cbs_pkg::POL_RR));
    write_reg(cbs_pkg::REG_QUANTUM, 8'd3);
    while (queued_loads < cbs_pkg::JOB_SLOTS + 3) add_rand_job();
    add_ctl(cbs_pkg::ACT_START);
    add_ticks(12);
    drain();
    write_reg(cbs_pkg::REG_POLICY, 8'(cbs_pkg::POL_FCFS));
    add_ticks(8);

    drain();
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
src/cbs_pkg.sv
src/cbs_ifs.sv
src/cbs_slot_alu.sv
src/cbs_engine.sv
src/cpu_io_burst_scheduler_core.sv
tb/sv/cpu_io_burst_scheduler_core_test.sv
